@@ sv/scts_pkg.sv @@
package scts_pkg;

    // strip and ring geometry
    localparam int STRIP_COLUMNS = 22;
    localparam int STRIP_ROWS    = 19;
    localparam int RING_TILES    = 32;
    localparam int INIT_ROWS     = 18;

    // screen geometry in pixels
    localparam int OFFSET_X      = 80;
    localparam int OFFSET_Y      = 72;
    localparam int SCREEN_W      = 160;
    localparam int SCREEN_H      = 144;
    localparam int EDGE_X        = 159;
    localparam int EDGE_Y        = 143;
    localparam int NARROW_TILES  = 20;
    localparam int TILE_SHIFT    = 3;

    localparam logic [7:0] MAP_WIDTH_RESET  = 8'd20;
    localparam logic [7:0] MAP_HEIGHT_RESET = 8'd18;

    // configuration register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // input modes
    localparam logic [1:0] MODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;
    localparam logic [1:0] MODE_SCROLL = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ROW    = 2'd0;
    localparam logic [1:0] KIND_COL    = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_CLAMP   = 3'd1;
    localparam logic [2:0] OP_INIT    = 3'd2;
    localparam logic [2:0] OP_UPDATE  = 3'd3;
    localparam logic [2:0] OP_INC_TY  = 3'd4;
    localparam logic [2:0] OP_LOAD_TY = 3'd5;
    localparam logic [2:0] OP_CLR_ROW = 3'd6;
    localparam logic [2:0] OP_CLR_COL = 3'd7;

    // result emission
    localparam logic [1:0] EMIT_NONE   = 2'd0;
    localparam logic [1:0] EMIT_ROW    = 2'd1;
    localparam logic [1:0] EMIT_COL    = 2'd2;
    localparam logic [1:0] EMIT_SCROLL = 2'd3;

    localparam logic PART_A = 1'b0;
    localparam logic PART_B = 1'b1;

    // what may still follow the current write
    localparam logic [1:0] MORE_NONE = 2'd0;
    localparam logic [1:0] MORE_RUN  = 2'd1;
    localparam logic [1:0] MORE_COL  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       fire;
        logic [2:0] op;
        logic [1:0] emit;
        logic       part;
        logic [1:0] more;
    } t_dp_ctrl;

    typedef struct packed {
        logic row_ok;
        logic row_split;
        logic col_split;
        logic row_pend;
        logic col_pend;
    } t_dp_status;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] world_index;
        logic [7:0] world_start;
        logic [4:0] buffer_offset;
        logic [4:0] ring_x;
        logic [4:0] ring_y;
        logic [4:0] width_tiles;
        logic [4:0] height_tiles;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic       last;
    } t_result;

endpackage

@@ sv/scts_sequencer.sv @@
module scts_sequencer
    import scts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  logic       i_slot_free,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_ctrl   o_ctrl
);

    localparam logic [2:0] COND_NEXT        = 3'd0;
    localparam logic [2:0] COND_ALWAYS      = 3'd1;
    localparam logic [2:0] COND_NO_ROW      = 3'd2;
    localparam logic [2:0] COND_NO_SPLIT    = 3'd3;
    localparam logic [2:0] COND_NO_ROW_PEND = 3'd4;
    localparam logic [2:0] COND_NO_COL_PEND = 3'd5;
    localparam logic [2:0] COND_DISPATCH    = 3'd6;

    localparam logic [4:0] S_IDLE        = 5'd0;
    localparam logic [4:0] S_INIT_CLAMP  = 5'd1;
    localparam logic [4:0] S_INIT_SET    = 5'd2;
    localparam logic [4:0] S_INIT_TEST   = 5'd3;
    localparam logic [4:0] S_INIT_ROW_A  = 5'd4;
    localparam logic [4:0] S_INIT_ROW_B  = 5'd5;
    localparam logic [4:0] S_INIT_INC    = 5'd6;
    localparam logic [4:0] S_UPD_CLAMP   = 5'd7;
    localparam logic [4:0] S_UPD_SET     = 5'd8;
    localparam logic [4:0] S_FL_START    = 5'd9;
    localparam logic [4:0] S_FL_ROW_A    = 5'd10;
    localparam logic [4:0] S_FL_ROW_B    = 5'd11;
    localparam logic [4:0] S_FL_COL_TEST = 5'd12;
    localparam logic [4:0] S_FL_COL_A    = 5'd13;
    localparam logic [4:0] S_FL_COL_B    = 5'd14;
    localparam logic [4:0] S_FL_END      = 5'd15;
    localparam logic [4:0] S_SCROLL      = 5'd16;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] emit;
        logic       part;
        logic [1:0] more;
        logic [2:0] cond;
        logic [4:0] target;
    } t_uword;

    logic [4:0] r_pc;
    logic [4:0] n_pc;
    t_uword     w_uw;
    logic       w_accept;
    logic       w_fire;
    logic       w_jump;
    logic [4:0] w_entry;

    // control store
    always_comb begin
        unique case (r_pc)
            S_IDLE:        w_uw = '{OP_NOP,     EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_DISPATCH,    S_IDLE};
            S_INIT_CLAMP:  w_uw = '{OP_CLAMP,   EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NEXT,        S_IDLE};
            S_INIT_SET:    w_uw = '{OP_INIT,    EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NEXT,        S_IDLE};
            S_INIT_TEST:   w_uw = '{OP_NOP,     EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NO_ROW,      S_IDLE};
            S_INIT_ROW_A:  w_uw = '{OP_NOP,     EMIT_ROW,    PART_A, MORE_RUN,
                                    COND_NO_SPLIT,    S_INIT_INC};
            S_INIT_ROW_B:  w_uw = '{OP_NOP,     EMIT_ROW,    PART_B, MORE_RUN,
                                    COND_NEXT,        S_IDLE};
            S_INIT_INC:    w_uw = '{OP_INC_TY,  EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_ALWAYS,      S_INIT_TEST};
            S_UPD_CLAMP:   w_uw = '{OP_CLAMP,   EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NEXT,        S_IDLE};
            S_UPD_SET:     w_uw = '{OP_UPDATE,  EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_ALWAYS,      S_IDLE};
            S_FL_START:    w_uw = '{OP_LOAD_TY, EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NO_ROW_PEND, S_FL_COL_TEST};
            S_FL_ROW_A:    w_uw = '{OP_NOP,     EMIT_ROW,    PART_A, MORE_COL,
                                    COND_NO_SPLIT,    S_FL_COL_TEST};
            S_FL_ROW_B:    w_uw = '{OP_NOP,     EMIT_ROW,    PART_B, MORE_COL,
                                    COND_NEXT,        S_IDLE};
            S_FL_COL_TEST: w_uw = '{OP_CLR_ROW, EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_NO_COL_PEND, S_IDLE};
            S_FL_COL_A:    w_uw = '{OP_NOP,     EMIT_COL,    PART_A, MORE_NONE,
                                    COND_NO_SPLIT,    S_FL_END};
            S_FL_COL_B:    w_uw = '{OP_NOP,     EMIT_COL,    PART_B, MORE_NONE,
                                    COND_NEXT,        S_IDLE};
            S_FL_END:      w_uw = '{OP_CLR_COL, EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_ALWAYS,      S_IDLE};
            S_SCROLL:      w_uw = '{OP_NOP,     EMIT_SCROLL, PART_A, MORE_NONE,
                                    COND_ALWAYS,      S_IDLE};
            default:       w_uw = '{OP_NOP,     EMIT_NONE,   PART_A, MORE_NONE,
                                    COND_ALWAYS,      S_IDLE};
        endcase
    end

    always_comb begin
        unique case (i_mode)
            MODE_INIT:   w_entry = S_INIT_CLAMP;
            MODE_UPDATE: w_entry = S_UPD_CLAMP;
            MODE_FLUSH:  w_entry = S_FL_START;
            MODE_SCROLL: w_entry = S_SCROLL;
            default:     w_entry = S_IDLE;
        endcase
    end

    always_comb begin
        case (w_uw.cond)
            COND_ALWAYS:      w_jump = 1'b1;
            COND_NO_ROW:      w_jump = !i_status.row_ok;
            COND_NO_SPLIT:    w_jump = (w_uw.emit == EMIT_COL) ? !i_status.col_split
                                                                : !i_status.row_split;
            COND_NO_ROW_PEND: w_jump = !i_status.row_pend;
            COND_NO_COL_PEND: w_jump = !i_status.col_pend;
            default:          w_jump = 1'b0;
        endcase
    end

    assign o_in_ready = (r_pc == S_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;

    // a step with a write waits for room in the output register
    assign w_fire = (r_pc == S_IDLE) ? w_accept
                                     : ((w_uw.emit == EMIT_NONE) || i_slot_free);

    always_comb begin
        n_pc = r_pc;
        if (w_fire) begin
            if (w_uw.cond == COND_DISPATCH) begin
                n_pc = w_entry;
            end else if (w_jump) begin
                n_pc = w_uw.target;
            end else begin
                n_pc = r_pc + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = '{load: w_accept, fire: w_fire, op: w_uw.op, emit: w_uw.emit,
                      part: w_uw.part, more: w_uw.more};

endmodule

@@ sv/scts_datapath.sv @@
module scts_datapath
    import scts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_ctrl    i_ctrl,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic [15:0] i_player_x,
    input  logic [15:0] i_player_y,
    output t_dp_status  o_status,
    output t_result     o_result
);

    logic [7:0]  r_map_w;
    logic [7:0]  r_map_h;
    logic [10:0] r_lim_x;
    logic [10:0] r_lim_y;
    logic [10:0] n_lim_x;
    logic [10:0] n_lim_y;
    logic [15:0] r_px;
    logic [15:0] r_py;
    logic [10:0] r_nx;
    logic [10:0] r_ny;
    logic [10:0] r_cam_x;
    logic [10:0] r_cam_y;
    logic [7:0]  r_snap;
    logic        r_row_pend;
    logic [7:0]  r_row_idx;
    logic        r_col_pend;
    logic [7:0]  r_col_idx;
    logic [8:0]  r_ty;

    logic signed [16:0] w_vx;
    logic signed [16:0] w_vy;
    logic [11:0] w_bot_o;
    logic [11:0] w_bot_n;
    logic [11:0] w_rgt_o;
    logic [11:0] w_rgt_n;
    logic        n_row_set;
    logic [7:0]  n_row_new;
    logic        n_col_set;
    logic [7:0]  n_col_new;

    logic [4:0]  w_rx_row;
    logic [5:0]  w_row_first;
    logic        w_row_split;
    logic [7:0]  w_cty;
    logic [5:0]  w_col_first;
    logic        w_col_split;
    logic [8:0]  w_ty_next;
    logic [8:0]  w_ty_end;
    logic        w_row_ok;
    logic        w_next_ok;
    logic        w_split;
    logic        w_more;

    function automatic logic [10:0] f_clamp(input logic signed [16:0] v,
                                            input logic [10:0] lim);
        logic [10:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({6'd0, lim})) begin
            r = lim;
        end else begin
            r = v[10:0];
        end
        return r;
    endfunction

    // camera limits follow the map size registers in the next cycle
    always_comb begin
        n_lim_x = (r_map_w > 8'(NARROW_TILES))
                ? ({r_map_w, 3'b000} - 11'(SCREEN_W)) : '0;
        n_lim_y = ({r_map_h, 3'b000} >= 11'(SCREEN_H))
                ? ({r_map_h, 3'b000} - 11'(SCREEN_H)) : '0;
    end

    assign w_vx = $signed({r_px[15], r_px}) - $signed(17'(OFFSET_X));
    assign w_vy = $signed({r_py[15], r_py}) - $signed(17'(OFFSET_Y));

    // edge events in the direction of motion
    assign w_bot_o = 12'(r_cam_y) + 12'(EDGE_Y);
    assign w_bot_n = 12'(r_ny) + 12'(EDGE_Y);
    assign w_rgt_o = 12'(r_cam_x) + 12'(EDGE_X);
    assign w_rgt_n = 12'(r_nx) + 12'(EDGE_X);

    always_comb begin
        n_row_set = 1'b0;
        n_row_new = r_ny[10:3];
        if (r_ny < r_cam_y) begin
            n_row_set = (r_ny[10:3] != r_cam_y[10:3]);
        end else if (r_ny > r_cam_y) begin
            n_row_new = w_bot_n[10:3];
            n_row_set = (w_bot_n[10:3] != w_bot_o[10:3]) && (w_bot_n[10:3] < r_map_h);
        end
    end

    always_comb begin
        n_col_set = 1'b0;
        n_col_new = r_nx[10:3];
        if (r_nx < r_cam_x) begin
            n_col_set = (r_nx[10:3] != r_cam_x[10:3]);
        end else if (r_nx > r_cam_x) begin
            n_col_new = w_rgt_n[10:3];
            n_col_set = (w_rgt_n[10:3] != w_rgt_o[10:3]) && (w_rgt_n[10:3] < r_map_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w    <= MAP_WIDTH_RESET;
            r_map_h    <= MAP_HEIGHT_RESET;
            r_lim_x    <= '0;
            r_lim_y    <= '0;
            r_cam_x    <= '0;
            r_cam_y    <= '0;
            r_snap     <= '0;
            r_row_pend <= 1'b0;
            r_row_idx  <= '0;
            r_col_pend <= 1'b0;
            r_col_idx  <= '0;
            r_ty       <= '0;
        end else begin
            r_lim_x <= n_lim_x;
            r_lim_y <= n_lim_y;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAP_WIDTH) begin
                    r_map_w <= i_cfg_data;
                end else begin
                    r_map_h <= i_cfg_data;
                end
            end
            if (i_ctrl.fire) begin
                unique case (i_ctrl.op)
                    OP_INIT: begin
                        r_row_pend <= 1'b0;
                        r_col_pend <= 1'b0;
                        r_cam_x    <= r_nx;
                        r_cam_y    <= r_ny;
                        r_snap     <= r_nx[10:3];
                        r_ty       <= 9'(r_ny[10:3]);
                    end
                    OP_UPDATE: begin
                        if (n_row_set && !r_row_pend) begin
                            r_row_pend <= 1'b1;
                            r_row_idx  <= n_row_new;
                        end
                        if (n_col_set && !r_col_pend) begin
                            r_col_pend <= 1'b1;
                            r_col_idx  <= n_col_new;
                        end
                        r_cam_x <= r_nx;
                        r_cam_y <= r_ny;
                        r_snap  <= r_nx[10:3];
                    end
                    OP_INC_TY:  r_ty       <= w_ty_next;
                    OP_LOAD_TY: r_ty       <= 9'(r_row_idx);
                    OP_CLR_ROW: r_row_pend <= 1'b0;
                    OP_CLR_COL: r_col_pend <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_px <= i_player_x;
            r_py <= i_player_y;
        end
        if (i_ctrl.fire && (i_ctrl.op == OP_CLAMP)) begin
            r_nx <= f_clamp(w_vx, r_lim_x);
            r_ny <= f_clamp(w_vy, r_lim_y);
        end
    end

    // ring wrap of the strips
    assign w_rx_row    = r_snap[4:0];
    assign w_row_split = ({1'b0, w_rx_row} + 6'(STRIP_COLUMNS)) > 6'(RING_TILES);
    assign w_row_first = 6'(RING_TILES) - {1'b0, w_rx_row};
    assign w_cty       = r_cam_y[10:3];
    assign w_col_split = ({1'b0, w_cty[4:0]} + 6'(STRIP_ROWS)) > 6'(RING_TILES);
    assign w_col_first = 6'(RING_TILES) - {1'b0, w_cty[4:0]};

    // init row run bounds
    assign w_ty_next = r_ty + 9'd1;
    assign w_ty_end  = 9'(r_cam_y[10:3]) + 9'(INIT_ROWS);
    assign w_row_ok  = (r_ty < w_ty_end) && (r_ty < 9'(r_map_h));
    assign w_next_ok = (w_ty_next < w_ty_end) && (w_ty_next < 9'(r_map_h));

    assign o_status = '{row_ok: w_row_ok, row_split: w_row_split, col_split: w_col_split,
                        row_pend: r_row_pend, col_pend: r_col_pend};

    always_comb begin
        case (i_ctrl.emit)
            EMIT_ROW: w_split = w_row_split;
            EMIT_COL: w_split = w_col_split;
            default:  w_split = 1'b0;
        endcase
        case (i_ctrl.more)
            MORE_RUN: w_more = w_next_ok;
            MORE_COL: w_more = r_col_pend;
            default:  w_more = 1'b0;
        endcase
    end

    always_comb begin
        o_result      = '0;
        o_result.last = ((i_ctrl.part == PART_B) || !w_split) && !w_more;
        case (i_ctrl.emit)
            EMIT_ROW: begin
                o_result.kind         = KIND_ROW;
                o_result.world_index  = r_ty[7:0];
                o_result.world_start  = r_snap;
                o_result.ring_y       = r_ty[4:0];
                o_result.height_tiles = 5'd1;
                if (i_ctrl.part == PART_B) begin
                    o_result.buffer_offset = w_row_first[4:0];
                    o_result.ring_x        = '0;
                    o_result.width_tiles   = 5'(6'(STRIP_COLUMNS) - w_row_first);
                end else begin
                    o_result.ring_x      = w_rx_row;
                    o_result.width_tiles = w_row_split ? w_row_first[4:0]
                                                       : 5'(STRIP_COLUMNS);
                end
            end
            EMIT_COL: begin
                o_result.kind        = KIND_COL;
                o_result.world_index = r_col_idx;
                o_result.world_start = w_cty;
                o_result.ring_x      = r_col_idx[4:0];
                o_result.width_tiles = 5'd1;
                if (i_ctrl.part == PART_B) begin
                    o_result.buffer_offset = w_col_first[4:0];
                    o_result.ring_y        = '0;
                    o_result.height_tiles  = 5'(6'(STRIP_ROWS) - w_col_first);
                end else begin
                    o_result.ring_y       = w_cty[4:0];
                    o_result.height_tiles = w_col_split ? w_col_first[4:0]
                                                        : 5'(STRIP_ROWS);
                end
            end
            EMIT_SCROLL: begin
                o_result.kind     = KIND_SCROLL;
                o_result.scroll_x = r_cam_x[7:0];
                o_result.scroll_y = r_cam_y[7:0];
            end
            default: ;
        endcase
    end

endmodule

@@ sv/scroll_camera_tile_streamer.sv @@
// Init writes one strip per visible row, up to 18 rows.
// Rate is set by the microcode step counter: one control word per cycle, one
// result per write step; a write step holds while the output register is full.
// First result appears in the cycle after its write step; output register decouples
// the two sides. Synchronous active-low reset returns the step counter to idle,
// clears camera and pending events, and sets map size to 20 by 18 tiles.
module scroll_camera_tile_streamer
    import scts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // player_x [15:0], player_y [31:16]
    input  logic [31:0] i_s_axis_tdata,
    // mode [1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // world_index [7:0], world_start [15:8], buffer_offset [20:16],
    // ring_x [25:21], ring_y [30:26], width_tiles [35:31],
    // height_tiles [40:36], scroll_x [48:41], scroll_y [56:49], zero [63:57]
    output logic [63:0] o_m_axis_tdata,
    // kind [1:0]
    output logic [1:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast
);

    t_dp_ctrl   w_ctrl;
    t_dp_status w_status;
    t_result    w_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       w_slot_free;
    logic       w_s_accept;

    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_s_accept  = i_s_axis_tvalid && o_s_axis_tready;

    scts_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_mode      (i_s_axis_tuser),
        .i_slot_free (w_slot_free),
        .i_status    (w_status),
        .o_in_ready  (o_s_axis_tready),
        .o_ctrl      (w_ctrl)
    );

    scts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_player_x  (i_s_axis_tdata[15:0]),
        .i_player_y  (i_s_axis_tdata[31:16]),
        .o_status    (w_status),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.fire && (w_ctrl.emit != EMIT_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the result on a write step; the step only fires when the slot is free
    always_ff @(posedge i_clk) begin
        if (w_ctrl.fire && (w_ctrl.emit != EMIT_NONE)) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {7'd0, r_out.scroll_y, r_out.scroll_x, r_out.height_tiles,
                              r_out.width_tiles, r_out.ring_y, r_out.ring_x,
                              r_out.buffer_offset, r_out.world_start, r_out.world_index};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_axis_tready)
        else $error("input taken again right after a transfer");

    a_scroll_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_SCROLL)) |-> o_m_axis_tlast)
        else $error("scroll report not marked last");

    a_row_fits_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_ROW)) |->
        ((r_out.height_tiles == 5'd1) &&
         ((6'(r_out.ring_x) + 6'(r_out.width_tiles)) <= 6'(RING_TILES))))
        else $error("row write crosses the ring edge");

    a_col_fits_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_COL)) |->
        ((r_out.width_tiles == 5'd1) &&
         ((6'(r_out.ring_y) + 6'(r_out.height_tiles)) <= 6'(RING_TILES))))
        else $error("column write crosses the ring edge");

endmodule

@@ tb/tb_scroll_camera_tile_streamer.sv @@
module tb_scroll_camera_tile_streamer;
    timeunit 1ns;
    timeprecision 1ps;
    import scts_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic signed [15:0] px;
        logic signed [15:0] py;
        bit                 settle;
    } t_player_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = 32'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // predictor copy of the block state and registers
    int map_w = MAP_WIDTH_RESET;
    int map_h = MAP_HEIGHT_RESET;
    int cam_x = 0;
    int cam_y = 0;
    int col_snap = 0;
    bit row_pend = 1'b0;
    int row_pend_idx = 0;
    bit col_pend = 1'b0;
    int col_pend_idx = 0;

    t_player_cmd player_q[$];
    t_result     write_req_q[$];
    t_result     step_out[$];
    t_player_cmd cur_cmd;
    int          feed_gap = 0;
    int          sink_stall = 0;
    int          feed_idle = 0;
    int          sink_idle = 0;
    int          fail_count = 0;

    int phase_w[6] = '{255, 1, 21, 32, 100, 40};
    int phase_h[6] = '{255, 18, 19, 10, 1, 254};

    scroll_camera_tile_streamer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_gap(int level);
        case (level)
            0: return 0;
            1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
            default: return int'($urandom_range(0, 16));
        endcase
    endfunction

    function automatic int pick(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int limit_pos(int v, int lim);
        if (v < 0) return 0;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic int lim_x();
        return (map_w > NARROW_TILES) ? map_w * 8 - SCREEN_W : 0;
    endfunction

    function automatic int lim_y();
        return (map_h * 8 >= SCREEN_H) ? map_h * 8 - SCREEN_H : 0;
    endfunction

    function automatic void add_res(logic [1:0] kind, int idx, int start, int off,
                                    int rx, int ry, int w, int h, int sx, int sy);
        t_result r;
        r.kind          = kind;
        r.world_index   = idx[7:0];
        r.world_start   = start[7:0];
        r.buffer_offset = off[4:0];
        r.ring_x        = rx[4:0];
        r.ring_y        = ry[4:0];
        r.width_tiles   = w[4:0];
        r.height_tiles  = h[4:0];
        r.scroll_x      = sx[7:0];
        r.scroll_y      = sy[7:0];
        r.last          = 1'b0;
        step_out.push_back(r);
    endfunction

    // split where the strip crosses the ring edge
    function automatic void queue_row(int ty);
        int rx, ry, first;
        rx = col_snap & (RING_TILES - 1);
        ry = ty & (RING_TILES - 1);
        if (rx + STRIP_COLUMNS > RING_TILES) begin
            first = RING_TILES - rx;
            add_res(KIND_ROW, ty, col_snap, 0, rx, ry, first, 1, 0, 0);
            add_res(KIND_ROW, ty, col_snap, first, 0, ry, STRIP_COLUMNS - first, 1, 0, 0);
        end else begin
            add_res(KIND_ROW, ty, col_snap, 0, rx, ry, STRIP_COLUMNS, 1, 0, 0);
        end
    endfunction

    function automatic void queue_col(int tx);
        int cty, rx, ry, first;
        cty = (cam_y >> TILE_SHIFT) & 255;
        rx = tx & (RING_TILES - 1);
        ry = cty & (RING_TILES - 1);
        if (ry + STRIP_ROWS > RING_TILES) begin
            first = RING_TILES - ry;
            add_res(KIND_COL, tx, cty, 0, rx, ry, 1, first, 0, 0);
            add_res(KIND_COL, tx, cty, first, rx, 0, 1, STRIP_ROWS - first, 0, 0);
        end else begin
            add_res(KIND_COL, tx, cty, 0, rx, ry, 1, STRIP_ROWS, 0, 0);
        end
    endfunction

    function automatic void step_camera(t_player_cmd c);
        int px, py, nx, ny, o, n, top;
        px = c.px;
        py = c.py;
        step_out.delete();
        case (c.mode)
            MODE_INIT: begin
                row_pend = 1'b0;
                col_pend = 1'b0;
                cam_y = limit_pos(py - OFFSET_Y, lim_y());
                cam_x = limit_pos(px - OFFSET_X, lim_x());
                top = cam_y >> TILE_SHIFT;
                col_snap = (cam_x >> TILE_SHIFT) & 255;
                for (int ty = top; ty < top + INIT_ROWS && ty < map_h; ty++)
                    queue_row(ty);
            end
            MODE_UPDATE: begin
                ny = limit_pos(py - OFFSET_Y, lim_y());
                nx = limit_pos(px - OFFSET_X, lim_x());
                if (ny < cam_y) begin
                    o = (cam_y >> TILE_SHIFT) & 255;
                    n = (ny >> TILE_SHIFT) & 255;
                    if (n != o && !row_pend) begin
                        row_pend = 1'b1;
                        row_pend_idx = n;
                    end
                end else if (ny > cam_y) begin
                    o = ((cam_y + EDGE_Y) >> TILE_SHIFT) & 255;
                    n = ((ny + EDGE_Y) >> TILE_SHIFT) & 255;
                    if (n != o && n < map_h && !row_pend) begin
                        row_pend = 1'b1;
                        row_pend_idx = n;
                    end
                end
                cam_y = ny;
                if (nx < cam_x) begin
                    o = (cam_x >> TILE_SHIFT) & 255;
                    n = (nx >> TILE_SHIFT) & 255;
                    if (n != o && !col_pend) begin
                        col_pend = 1'b1;
                        col_pend_idx = n;
                    end
                end else if (nx > cam_x) begin
                    o = ((cam_x + EDGE_X) >> TILE_SHIFT) & 255;
                    n = ((nx + EDGE_X) >> TILE_SHIFT) & 255;
                    if (n != o && n < map_w && !col_pend) begin
                        col_pend = 1'b1;
                        col_pend_idx = n;
                    end
                end
                cam_x = nx;
                col_snap = (cam_x >> TILE_SHIFT) & 255;
            end
            MODE_FLUSH: begin
                if (row_pend) queue_row(row_pend_idx);
                row_pend = 1'b0;
                if (col_pend) queue_col(col_pend_idx);
                col_pend = 1'b0;
            end
            default: begin
                add_res(KIND_SCROLL, 0, 0, 0, 0, 0, 0, 0, cam_x & 255, cam_y & 255);
            end
        endcase
        if (step_out.size() != 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) write_req_q.push_back(step_out[i]);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : feed
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (s_tvalid) step_camera(cur_cmd);
            if (feed_gap > 0) begin
                feed_gap--;
                s_tvalid <= 1'b0;
            end else if (player_q.size() != 0 &&
                         !(player_q[0].settle && write_req_q.size() != 0)) begin
                cur_cmd = player_q.pop_front();
                s_tdata <= {cur_cmd.py, cur_cmd.px};
                s_tuser <= cur_cmd.mode;
                s_tvalid <= 1'b1;
                feed_gap = draw_gap(feed_idle);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : sink
        int stall;
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            stall = sink_stall;
            if (o_m_axis_tvalid && m_tready) begin
                if (write_req_q.size() == 0) begin
                    $error("unexpected transfer: kind %0d tdata %h",
                           o_m_axis_tuser, o_m_axis_tdata);
                    fail_count++;
                end else begin
                    want = write_req_q.pop_front();
                    check_field("kind", want.kind, o_m_axis_tuser);
                    check_field("world_index", want.world_index, o_m_axis_tdata[7:0]);
                    check_field("world_start", want.world_start, o_m_axis_tdata[15:8]);
                    check_field("buffer_offset", want.buffer_offset, o_m_axis_tdata[20:16]);
                    check_field("ring_x", want.ring_x, o_m_axis_tdata[25:21]);
                    check_field("ring_y", want.ring_y, o_m_axis_tdata[30:26]);
                    check_field("width_tiles", want.width_tiles, o_m_axis_tdata[35:31]);
                    check_field("height_tiles", want.height_tiles, o_m_axis_tdata[40:36]);
                    check_field("scroll_x", want.scroll_x, o_m_axis_tdata[48:41]);
                    check_field("scroll_y", want.scroll_y, o_m_axis_tdata[56:49]);
                    check_field("last", want.last, o_m_axis_tlast);
                end
                stall = draw_gap(sink_idle);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                sink_stall = stall - 1;
            end else begin
                m_tready <= 1'b1;
                sink_stall = 0;
            end
        end
    end

    task automatic add_cmd(int mode, int px, int py, bit settle);
        t_player_cmd c;
        c.mode = mode[1:0];
        c.px = px[15:0];
        c.py = py[15:0];
        c.settle = settle;
        player_q.push_back(c);
    endtask

    task automatic write_reg(logic idx, int val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[7:0];
        if (idx == CFG_MAP_WIDTH) map_w = val;
        else map_h = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // hold until every command is taken and every write has come back
    task automatic settle_all();
        do @(negedge i_clk);
        while (player_q.size() != 0 || s_tvalid || write_req_q.size() != 0);
        repeat (100) @(negedge i_clk);
    endtask

    // player walk with random content, mostly update/flush frames, some noise
    task automatic walk_phase(int count);
        int px, py, span_x, span_y, stride, added;
        span_x = map_w * 8;
        span_y = map_h * 8;
        px = pick(-100, span_x + 100);
        py = pick(-100, span_y + 100);
        add_cmd(MODE_INIT, px, py, 1'b0);
        added = 1;
        while (added < count) begin
            case ($urandom_range(0, 19))
                0, 1: begin
                    add_cmd($urandom_range(0, 3), $urandom, $urandom, 1'b0);
                    added++;
                end
                2: begin
                    px = pick(-100, span_x + 100);
                    py = pick(-100, span_y + 100);
                    add_cmd(MODE_INIT, px, py, 1'b0);
                    added++;
                end
                default: begin
                    stride = ($urandom_range(0, 9) == 0) ? 80 : 12;
                    px = px + pick(-stride, stride);
                    py = py + pick(-stride, stride);
                    if (px < -300) px = -300;
                    if (px > span_x + 300) px = span_x + 300;
                    if (py < -300) py = -300;
                    if (py > span_y + 300) py = span_y + 300;
                    add_cmd(MODE_UPDATE, px, py, $urandom_range(0, 19) == 0);
                    added++;
                    if ($urandom_range(0, 9) < 7) begin
                        add_cmd(MODE_FLUSH, $urandom, $urandom, 1'b0);
                        added++;
                    end
                    if ($urandom_range(0, 4) == 0) begin
                        add_cmd(MODE_SCROLL, $urandom, $urandom, 1'b0);
                        added++;
                    end
                end
            endcase
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset map: the camera cannot move at all
        add_cmd(MODE_SCROLL, 0, 0, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b0);
        add_cmd(MODE_INIT, -32768, -32768, 1'b0);
        add_cmd(MODE_INIT, 32767, 32767, 1'b0);
        add_cmd(MODE_UPDATE, 32767, -32768, 1'b0);
        add_cmd(MODE_SCROLL, 32'hFFFF, 32'hFFFF, 1'b0);
        settle_all();

        write_reg(CFG_MAP_WIDTH, 64);
        write_reg(CFG_MAP_HEIGHT, 40);
        feed_idle = 1;
        sink_idle = 1;
        // both strips straddle the ring edge, then events up/left, dropped, down/right
        add_cmd(MODE_INIT, 200, 200, 1'b0);
        add_cmd(MODE_UPDATE, 192, 192, 1'b0);
        add_cmd(MODE_UPDATE, 184, 184, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b0);
        add_cmd(MODE_UPDATE, 200, 200, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b1);
        add_cmd(MODE_UPDATE, 32767, 32767, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b0);
        add_cmd(MODE_SCROLL, 0, 0, 1'b0);
        add_cmd(MODE_UPDATE, -32768, -32768, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b0);
        add_cmd(MODE_FLUSH, 0, 0, 1'b0);
        add_cmd(MODE_INIT, 32'h5555, 32'hAAAA, 1'b1);
        settle_all();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MAP_WIDTH, phase_w[p]);
            write_reg(CFG_MAP_HEIGHT, phase_h[p]);
            feed_idle = $urandom_range(0, 2);
            sink_idle = $urandom_range(0, 2);
            walk_phase(60);
            settle_all();
        end

        if (fail_count == 0 && write_req_q.size() == 0) begin
            $display("tb_scroll_camera_tile_streamer passed");
        end else begin
            $display("tb_scroll_camera_tile_streamer failed");
        end
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("tb_scroll_camera_tile_streamer failed");
        $finish;
    end

endmodule
